### hw/rtl/lwfs_pkg.sv
// ----------------------------------------------------------------------------
// lwfs_pkg
// Shared types and constants for the LED window fade sequencer: table entry,
// controller states, command and status bundles, mode and channel codes.
// ----------------------------------------------------------------------------
package lwfs_pkg;

    localparam int LED_COUNT_DEF = 16;
    localparam int IDX_W         = 6;
    localparam int DIV_W         = 32;
    localparam int DIVR_W        = 18;
    localparam int CNT_W         = $clog2(DIV_W);

    localparam logic       ACT_WRITE = 1'b0;
    localparam logic       ACT_TICK  = 1'b1;

    localparam logic [2:0] MODE_ON   = 3'd0;
    localparam logic [2:0] MODE_UP   = 3'd1;
    localparam logic [2:0] MODE_DOWN = 3'd2;
    localparam logic [2:0] MODE_TRI  = 3'd3;
    localparam logic [2:0] MODE_VEE  = 3'd4;

    localparam logic [1:0] CH_RED    = 2'd0;
    localparam logic [1:0] CH_GREEN  = 2'd1;
    localparam logic [1:0] CH_BLUE   = 2'd2;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] wstart;
        logic [15:0] wend;
        logic [2:0]  mode;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_WINDOW,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_STORE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             div_mod;
        logic             div_ch;
        logic             win_en;
        logic             mul_en;
        logic             store_en;
        logic             out_load;
        logic             tick_inc;
        logic             last;
        logic [1:0]       ch;
        logic [IDX_W-1:0] led;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/led_window_fade_sequencer_core.sv
// ----------------------------------------------------------------------------
// led_window_fade_sequencer_core
// Per-LED windowed fade sequencer: table writes, and per tick one faded colour
// for every LED followed by a tick counter advance.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_stall  action, led_index, period, window,
//                                           fade_mode, red, green, blue
//   output    out        o_valid / i_stall  pixel_index, out_red/green/blue,
//                                           frame_last
//
// A table write is accepted only while idle. A tick walks the LEDs in order,
// and the input stalls until the frame ends: one 32-step divider
// does the position modulo and then the three channel divisions for each LED.
// Reset (synchronous, active low) clears the tick counter and the entry valid
// bits; an unwritten entry reads as dark. A stalled result is held while the
// next LED is computed; the sequencer waits only when that result is done too.
// ----------------------------------------------------------------------------
module led_window_fade_sequencer_core #(
    parameter int LED_COUNT = lwfs_pkg::LED_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_action,
    input  logic [lwfs_pkg::IDX_W-1:0] i_led_index,
    input  logic [15:0]               i_period,
    input  logic [15:0]               i_window_start,
    input  logic [15:0]               i_window_end,
    input  logic [2:0]                i_fade_mode,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [lwfs_pkg::IDX_W-1:0] o_pixel_index,
    output logic [7:0]                o_out_red,
    output logic [7:0]                o_out_green,
    output logic [7:0]                o_out_blue,
    output logic                      o_frame_last
);
    import lwfs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    lwfs_ctrl #(
        .LED_COUNT (LED_COUNT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    lwfs_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_led_index    (i_led_index),
        .i_period       (i_period),
        .i_window_start (i_window_start),
        .i_window_end   (i_window_end),
        .i_fade_mode    (i_fade_mode),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_index  (o_pixel_index),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_frame_last   (o_frame_last)
    );

endmodule

### hw/rtl/lwfs_div.sv
// ----------------------------------------------------------------------------
// lwfs_div
// Restoring divider, one quotient bit per cycle. Serves both the position
// modulo and the per-channel level divisions.
// ----------------------------------------------------------------------------
module lwfs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lwfs_pkg::DIV_W-1:0]  i_dividend,
    input  logic [lwfs_pkg::DIVR_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [lwfs_pkg::DIV_W-1:0]  o_quotient,
    output logic [lwfs_pkg::DIVR_W-1:0] o_remainder
);
    import lwfs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_dvd;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_dsr;
    logic [DIVR_W:0]   w_sh;
    logic              w_ge;

    assign w_sh = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(DIV_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? DIVR_W'(w_sh - {1'b0, r_dsr}) : w_sh[DIVR_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule

### hw/rtl/lwfs_datapath.sv
// ----------------------------------------------------------------------------
// lwfs_datapath
// LED table memory with valid bits, tick counter, window and fraction
// arithmetic, shared divider and the output register.
// ----------------------------------------------------------------------------
module lwfs_datapath #(
    parameter int LED_COUNT = lwfs_pkg::LED_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lwfs_pkg::t_cmd            i_cmd,
    output lwfs_pkg::t_sts            o_sts,
    input  logic [lwfs_pkg::IDX_W-1:0] i_led_index,
    input  logic [15:0]               i_period,
    input  logic [15:0]               i_window_start,
    input  logic [15:0]               i_window_end,
    input  logic [2:0]                i_fade_mode,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [lwfs_pkg::IDX_W-1:0] o_pixel_index,
    output logic [7:0]                o_out_red,
    output logic [7:0]                o_out_green,
    output logic [7:0]                o_out_blue,
    output logic                      o_frame_last
);
    import lwfs_pkg::*;

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    t_entry                r_mem [LED_COUNT];
    logic [LED_COUNT-1:0]  r_vld;
    t_entry                r_rd_ent;
    logic                  r_rd_vld;
    t_entry                w_ent;
    logic                  w_idx_ok;

    logic [31:0]           r_tick;
    logic signed [18:0]    r_off;
    logic signed [18:0]    r_duty;
    logic                  r_lit;
    logic [26:0]           r_prod;
    logic                  r_nonpos;
    logic [7:0]            r_lvl [3];

    logic                  r_o_valid;
    logic [IDX_W-1:0]      r_o_idx;
    logic [7:0]            r_o_red;
    logic [7:0]            r_o_green;
    logic [7:0]            r_o_blue;
    logic                  r_o_last;

    logic signed [18:0]    w_p, w_s, w_e, w_pos;
    logic signed [18:0]    n_off, n_duty;
    logic                  n_lit;
    logic signed [18:0]    w_half;
    logic signed [20:0]    w_off21, w_duty21, w_num;
    logic [7:0]            w_c;
    logic [7:0]            w_lvl;

    logic                  w_div_start;
    logic [DIV_W-1:0]      w_dividend;
    logic [DIVR_W-1:0]     w_divisor;
    logic                  w_div_busy;
    logic                  w_div_done;
    logic [DIV_W-1:0]      w_quot;
    logic [DIVR_W-1:0]     w_rem;

    assign w_idx_ok = ({1'b0, i_led_index} < (IDX_W + 1)'(LED_COUNT));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_idx_ok) begin
            r_mem[i_led_index[AW-1:0]] <= '{period: i_period, wstart: i_window_start,
                                            wend: i_window_end, mode: i_fade_mode,
                                            red: i_red, green: i_green, blue: i_blue};
        end
        if (i_cmd.rd_en) begin
            r_rd_ent <= r_mem[i_cmd.led[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.wr_en && w_idx_ok) begin
                r_vld[i_led_index[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_vld[i_cmd.led[AW-1:0]];
            end
        end
    end

    assign w_ent = r_rd_vld ? r_rd_ent : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (i_cmd.tick_inc) begin
            r_tick <= r_tick + 32'd1;
        end
    end

    assign w_div_start = i_cmd.div_mod || i_cmd.div_ch;
    assign w_dividend  = i_cmd.div_mod ? r_tick : {5'b0, r_prod};
    assign w_divisor   = i_cmd.div_mod ? {2'b0, w_ent.period} : r_duty[DIVR_W-1:0];

    lwfs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_busy      (w_div_busy),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    assign w_p   = signed'({3'b0, w_ent.period});
    assign w_s   = signed'({3'b0, w_ent.wstart});
    assign w_e   = signed'({3'b0, w_ent.wend});
    assign w_pos = signed'({3'b0, w_rem[15:0]});

    always_comb begin
        n_off  = '0;
        n_duty = '0;
        n_lit  = 1'b0;
        if (w_p != 19'sd0) begin
            if (w_s < w_e) begin
                n_duty = w_e - w_s;
                n_off  = w_pos - w_s;
                n_lit  = (w_pos >= w_s) && (w_pos <= w_e);
            end else begin
                n_duty = w_e + w_p - w_s;
                if (w_pos <= w_e) begin
                    n_off = w_pos + w_p - w_s;
                    n_lit = 1'b1;
                end else if (w_pos >= w_s) begin
                    n_off = w_pos - w_s;
                    n_lit = 1'b1;
                end
            end
            if (n_duty <= 19'sd0) begin
                n_lit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_en) begin
            r_off  <= n_off;
            r_duty <= n_duty;
            r_lit  <= n_lit;
        end
    end

    always_comb begin
        case (i_cmd.ch)
            CH_RED:   w_c = w_ent.red;
            CH_GREEN: w_c = w_ent.green;
            default:  w_c = w_ent.blue;
        endcase
    end

    assign w_half   = r_duty >>> 1;
    assign w_off21  = {{2{r_off[18]}}, r_off};
    assign w_duty21 = {{2{r_duty[18]}}, r_duty};

    always_comb begin
        case (w_ent.mode)
            MODE_UP:   w_num = w_off21;
            MODE_DOWN: w_num = w_duty21 - w_off21;
            MODE_TRI:  w_num = (r_off < w_half) ? (w_off21 <<< 1)
                                                : ((w_duty21 - w_off21) <<< 1);
            MODE_VEE:  w_num = (r_off > w_half) ? ((w_off21 <<< 1) - w_duty21)
                                                : (w_duty21 - (w_off21 <<< 1));
            default:   w_num = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_nonpos <= (w_num <= 21'sd0);
            r_prod   <= {19'b0, w_c} * {8'b0, w_num[18:0]};
        end
    end

    always_comb begin
        w_lvl = '0;
        if (r_lit) begin
            case (w_ent.mode) inside
                MODE_ON: begin
                    w_lvl = w_c;
                end
                [MODE_UP:MODE_VEE]: begin
                    if (!r_nonpos) begin
                        w_lvl = (|w_quot[DIV_W-1:8]) ? 8'hFF : w_quot[7:0];
                    end
                end
                default: begin
                    w_lvl = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_en) begin
            r_lvl[i_cmd.ch] <= w_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_idx   <= i_cmd.led;
            r_o_red   <= r_lvl[CH_RED];
            r_o_green <= r_lvl[CH_GREEN];
            r_o_blue  <= r_lvl[CH_BLUE];
            r_o_last  <= i_cmd.last;
        end
    end

    assign o_sts.div_busy = w_div_busy;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_o_valid || !i_stall;

    assign o_valid       = r_o_valid;
    assign o_pixel_index = r_o_idx;
    assign o_out_red     = r_o_red;
    assign o_out_green   = r_o_green;
    assign o_out_blue    = r_o_blue;
    assign o_frame_last  = r_o_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_o_valid || !i_stall))
        else $error("output register loaded while holding a stalled result");

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> (r_o_valid && $stable(r_o_idx) && $stable(r_o_red)))
        else $error("stalled result changed");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (!w_div_busy && !i_cmd.rd_en))
        else $error("table write during a frame");

endmodule

### hw/rtl/lwfs_ctrl.sv
// ----------------------------------------------------------------------------
// lwfs_ctrl
// Sequencer for one frame: walk the LEDs, and for each one run the position
// modulo, the window step and three channel divisions, then emit a result.
// ----------------------------------------------------------------------------
module lwfs_ctrl #(
    parameter int LED_COUNT = lwfs_pkg::LED_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_action,
    output logic           o_stall,
    input  lwfs_pkg::t_sts i_sts,
    output lwfs_pkg::t_cmd o_cmd
);
    import lwfs_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_led;
    logic [1:0]       r_ch;
    logic             w_last;
    logic             w_tick_acc;

    assign w_last     = (r_led == IDX_W'(LED_COUNT - 1));
    assign w_tick_acc = (r_state == ST_IDLE) && i_valid && (i_action == ACT_TICK);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (w_tick_acc) n_state = ST_READ;
            ST_READ:     n_state = ST_MOD_GO;
            ST_MOD_GO:   n_state = ST_MOD_WAIT;
            ST_MOD_WAIT: if (i_sts.div_done) n_state = ST_WINDOW;
            ST_WINDOW:   n_state = ST_MUL;
            ST_MUL:      n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: if (i_sts.div_done) n_state = ST_STORE;
            ST_STORE:    n_state = (r_ch == CH_BLUE) ? ST_EMIT : ST_MUL;
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = w_last ? ST_IDLE : ST_READ;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.ch   = r_ch;
        o_cmd.led  = r_led;
        o_cmd.last = w_last;
        o_stall    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall     = 1'b0;
                o_cmd.wr_en = i_valid && (i_action == ACT_WRITE);
            end
            ST_READ:   o_cmd.rd_en    = 1'b1;
            ST_MOD_GO: o_cmd.div_mod  = 1'b1;
            ST_WINDOW: o_cmd.win_en   = 1'b1;
            ST_MUL:    o_cmd.mul_en   = 1'b1;
            ST_DIV_GO: o_cmd.div_ch   = 1'b1;
            ST_STORE:  o_cmd.store_en = 1'b1;
            ST_EMIT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.tick_inc = i_sts.out_free && w_last;
            end
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_led   <= '0;
            r_ch    <= CH_RED;
        end else begin
            r_state <= n_state;
            if (w_tick_acc) begin
                r_led <= '0;
            end else if ((r_state == ST_EMIT) && i_sts.out_free && !w_last) begin
                r_led <= r_led + 1'b1;
            end
            if (r_state == ST_WINDOW) begin
                r_ch <= CH_RED;
            end else if ((r_state == ST_STORE) && (r_ch != CH_BLUE)) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_acc |=> (r_state == ST_READ) && (r_led == '0))
        else $error("frame did not start at the first LED");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_sts.out_free && w_last) |=> (r_state == ST_IDLE))
        else $error("frame did not end after the last LED");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ch == CH_RED) || (r_ch == CH_GREEN) || (r_ch == CH_BLUE))
        else $error("channel counter out of range");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_mod || o_cmd.div_ch) |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_led_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> ({1'b0, r_led} < (IDX_W + 1)'(LED_COUNT)))
        else $error("LED counter beyond table");

endmodule
